>>> hw/rtl/cell_balance_policy_top_defines.svh
// Assertion macros used by the cell balance policy top RTL.
`ifndef CELL_BALANCE_POLICY_TOP_DEFINES_SVH
`define CELL_BALANCE_POLICY_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define CBP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define CBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/cbp_pkg.sv
// Types and constants for the cell balance policy block.
package cbp_pkg;

    localparam int MASK_W     = 18;
    localparam int MV_W       = 13;
    localparam int RAW_W      = 16;
    localparam int SUM_W      = 17;
    localparam int IDX_W      = 5;
    localparam int CMD_W      = 3;
    localparam int FET_W      = 5;
    localparam int STAT_W     = 4;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    // x / 10 == (x * 0xCCCD) >> 19 for any 16-bit x
    localparam logic [31:0] DIV10_MUL   = 32'd52429;
    localparam int          DIV10_SHIFT = 19;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_PRESENT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_LOW      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_HIGH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX           = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN           = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VERY_LOW      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_DELTA  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HYST_LOW      = 3'd7;

    // register reset values
    localparam logic [MV_W-1:0] RST_OPEN_HIGH    = 13'd6553;
    localparam logic [MV_W-1:0] RST_MAX          = 13'd3500;
    localparam logic [MV_W-1:0] RST_MIN          = 13'd2600;
    localparam logic [MV_W-1:0] RST_VERY_LOW     = 13'd2550;
    localparam logic [MV_W-1:0] RST_TARGET_DELTA = 13'd3400;
    localparam logic [MV_W-1:0] RST_HYST_LOW     = 13'd3300;

    // FET bit positions
    localparam int FET_DUMP_BIT   = 0;
    localparam int FET_DUMP2_BIT  = 1;
    localparam int FET_HEATER_BIT = 2;
    localparam int FET_CHGR_BIT   = 3;
    localparam int FET_VLC_BIT    = 4;

    // status bit positions
    localparam int ST_OPEN_BIT = 0;
    localparam int ST_HIGH_BIT = 1;
    localparam int ST_LOW_BIT  = 2;
    localparam int ST_VLOW_BIT = 3;

    // mode bit positions
    localparam int MODE_RELAX_BIT = 0;
    localparam int MODE_TRIP_BIT  = 1;

    typedef struct packed {
        logic [MASK_W-1:0] cells_present;
        logic [MV_W-1:0]   open_low;
        logic [MV_W-1:0]   open_high;
        logic [MV_W-1:0]   max_mv;
        logic [MV_W-1:0]   min_mv;
        logic [MV_W-1:0]   very_low;
        logic [MV_W-1:0]   target_delta;
        logic [MV_W-1:0]   hyst_low;
    } cfg_t;

    typedef struct packed {
        logic [MV_W-1:0]   mv;
        logic              last;
        logic [CMD_W-1:0]  cmd_active;
        logic [CMD_W-1:0]  cmd_on;
        logic [CMD_W-1:0]  cmd_expired;
        logic              rb_active;
        logic [MASK_W-1:0] rb_mask;
        logic              test_req;
        logic              trip_req;
    } item_t;

    // per-cycle tracker values after the current cell is taken
    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [MV_W-1:0]   high_mv;
        logic [IDX_W-1:0]  high_idx;
        logic [MV_W-1:0]   low_mv;
        logic [IDX_W-1:0]  low_idx;
        logic [MASK_W-1:0] over;
        logic [MASK_W-1:0] below;
        logic [MASK_W-1:0] vlow;
        logic [MASK_W-1:0] bal;
        logic [STAT_W-1:0] status;
        logic [MASK_W-1:0] trip_set;
        logic [MASK_W-1:0] hyst_set;
    } cyc_t;

endpackage

>>> hw/rtl/cell_balance_policy_top.sv
// Cell balance policy top: input register, cell trackers, decision and result register.
// A last-cell transaction passes from the input register into the result register, which raises out_valid.
// Throughput: one cell reading per cycle while in_stall is low; the input register to result
// register path is the only stage. A last-cell transaction waits in the input register while a
// previous result is stalled at the output.
// Reset: rst_n is asynchronous, active low; clears control state, loads config defaults.
`include "cell_balance_policy_top_defines.svh"

module cell_balance_policy_top #(
    parameter int NUM_CELLS = 18
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [cbp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cbp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [cbp_pkg::RAW_W-1:0]      cell_reading,
    input  logic                           last_cell,
    input  logic [cbp_pkg::CMD_W-1:0]      cmd_active_mask,
    input  logic [cbp_pkg::CMD_W-1:0]      cmd_on_mask,
    input  logic [cbp_pkg::CMD_W-1:0]      cmd_expired_mask,
    input  logic                           remote_balance_active,
    input  logic [cbp_pkg::MASK_W-1:0]     remote_balance_mask,
    input  logic                           discharge_test_request,
    input  logic                           trip_request,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [cbp_pkg::MASK_W-1:0]     balance_mask,
    output logic [cbp_pkg::FET_W-1:0]      fet_bits,
    output logic [cbp_pkg::STAT_W-1:0]     pack_status,
    output logic [cbp_pkg::MODE_W-1:0]     mode_bits,
    output logic [cbp_pkg::SUM_W-1:0]      total_mv,
    output logic [cbp_pkg::MV_W-1:0]       high_mv,
    output logic [cbp_pkg::IDX_W-1:0]      high_index,
    output logic [cbp_pkg::MV_W-1:0]       low_mv,
    output logic [cbp_pkg::IDX_W-1:0]      low_index,
    output logic [cbp_pkg::MASK_W-1:0]     over_max_mask,
    output logic [cbp_pkg::MASK_W-1:0]     below_min_mask,
    output logic [cbp_pkg::MASK_W-1:0]     very_low_mask
);
    import cbp_pkg::*;

    cfg_t              cfg;
    cyc_t              cyc;
    item_t             in_item;
    item_t             s1_item_reg;
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_go;
    logic              in_accept;
    logic [31:0]       div_prod;
    logic [MASK_W-1:0] trip_mask;
    logic              relax;

    // reading / 10 by reciprocal multiply, done ahead of the input register
    assign div_prod = 32'(cell_reading) * DIV10_MUL;

    always_comb
    begin
        in_item.mv          = div_prod[DIV10_SHIFT +: MV_W];
        in_item.last        = last_cell;
        in_item.cmd_active  = cmd_active_mask;
        in_item.cmd_on      = cmd_on_mask;
        in_item.cmd_expired = cmd_expired_mask;
        in_item.rb_active   = remote_balance_active;
        in_item.rb_mask     = remote_balance_mask;
        in_item.test_req    = discharge_test_request;
        in_item.trip_req    = trip_request;
    end

    // only a last-cell transaction needs the result register free
    assign s1_go     = s1_valid_reg && !(s1_item_reg.last && out_valid && out_stall);
    assign in_stall  = s1_valid_reg && !s1_go;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_item_reg <= in_item;
        end
    end

    cbp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cbp_tracker #(
        .NUM_CELLS (NUM_CELLS)
    ) u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (s1_go),
        .item      (s1_item_reg),
        .cfg       (cfg),
        .trip_mask (trip_mask),
        .relax     (relax),
        .cyc       (cyc)
    );

    cbp_policy u_policy (
        .clk            (clk),
        .rst_n          (rst_n),
        .go             (s1_go),
        .item           (s1_item_reg),
        .cfg            (cfg),
        .cyc            (cyc),
        .out_stall      (out_stall),
        .trip_mask      (trip_mask),
        .relax          (relax),
        .out_valid      (out_valid),
        .balance_mask   (balance_mask),
        .fet_bits       (fet_bits),
        .pack_status    (pack_status),
        .mode_bits      (mode_bits),
        .total_mv       (total_mv),
        .high_mv        (high_mv),
        .high_index     (high_index),
        .low_mv         (low_mv),
        .low_index      (low_index),
        .over_max_mask  (over_max_mask),
        .below_min_mask (below_min_mask),
        .very_low_mask  (very_low_mask)
    );

    `CBP_ASSERT_IMPL(a_mid_no_stall, s1_valid_reg && !s1_item_reg.last, !in_stall, "non-last cell stalled")
    `CBP_ASSERT_NEXT(a_last_gives_result, s1_go && s1_item_reg.last, out_valid, "last cell without result")
    `CBP_ASSERT_IMPL(a_result_source, $rose(out_valid), $past(s1_go && s1_item_reg.last), "result without last cell")
    `CBP_ASSERT_IMPL(a_open_shutdown, out_valid && pack_status[ST_OPEN_BIT], balance_mask == '0 && fet_bits == '0, "open wire with FETs on")
    `CBP_ASSERT_IMPL(a_relax_no_charge, out_valid && !pack_status[ST_OPEN_BIT] && mode_bits[MODE_RELAX_BIT], !fet_bits[FET_CHGR_BIT] && !fet_bits[FET_VLC_BIT], "charger on in relaxation")

endmodule

>>> hw/rtl/cbp_cfg_regs.sv
// Configuration register file with write port.
module cbp_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [cbp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cbp_pkg::CFG_DATA_W-1:0] cfg_data,
    output cbp_pkg::cfg_t                  cfg
);
    import cbp_pkg::*;

    cfg_t            cfg_reg;
    cfg_t            cfg_next;
    logic [MV_W-1:0] data_mv;

    assign data_mv = cfg_data[MV_W-1:0];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_CELLS_PRESENT: cfg_next.cells_present = cfg_data[MASK_W-1:0];
                REG_OPEN_LOW:      cfg_next.open_low      = data_mv;
                REG_OPEN_HIGH:     cfg_next.open_high     = data_mv;
                REG_MAX:           cfg_next.max_mv        = data_mv;
                REG_MIN:           cfg_next.min_mv        = data_mv;
                REG_VERY_LOW:      cfg_next.very_low      = data_mv;
                REG_TARGET_DELTA:  cfg_next.target_delta  = data_mv;
                REG_HYST_LOW:      cfg_next.hyst_low      = data_mv;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cells_present <= '0;
            cfg_reg.open_low      <= '0;
            cfg_reg.open_high     <= RST_OPEN_HIGH;
            cfg_reg.max_mv        <= RST_MAX;
            cfg_reg.min_mv        <= RST_MIN;
            cfg_reg.very_low      <= RST_VERY_LOW;
            cfg_reg.target_delta  <= RST_TARGET_DELTA;
            cfg_reg.hyst_low      <= RST_HYST_LOW;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hw/rtl/cbp_tracker.sv
// Per-cycle cell trackers: counter, sum, high/low, cycle masks and status.
module cbp_tracker #(
    parameter int NUM_CELLS = 18
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        go,
    input  cbp_pkg::item_t              item,
    input  cbp_pkg::cfg_t               cfg,
    input  logic [cbp_pkg::MASK_W-1:0]  trip_mask,
    input  logic                        relax,
    output cbp_pkg::cyc_t               cyc
);
    import cbp_pkg::*;

    localparam int CNT_W = $clog2(NUM_CELLS + 1);

    logic [CNT_W-1:0]  cnt_reg,    cnt_next;
    logic [SUM_W-1:0]  sum_reg;
    logic [MV_W-1:0]   high_reg;
    logic [IDX_W-1:0]  hidx_reg;
    logic [MV_W-1:0]   low_reg;
    logic [IDX_W-1:0]  lidx_reg;
    logic [MASK_W-1:0] over_reg;
    logic [MASK_W-1:0] below_reg;
    logic [MASK_W-1:0] vlow_reg;
    logic [MASK_W-1:0] bal_reg;
    logic [STAT_W-1:0] status_reg;
    cyc_t              cyc_next;

    logic              start;
    logic              in_range;
    logic [MASK_W-1:0] cell_bit;
    logic              present;
    logic              is_open;
    logic              good;
    logic              over;
    logic [IDX_W-1:0]  cell_idx;

    assign start    = (cnt_reg == '0);
    assign in_range = (cnt_reg < CNT_W'(NUM_CELLS)) && (int'(cnt_reg) < MASK_W);
    assign cell_bit = in_range ? (MASK_W'(1) << cnt_reg) : '0;
    assign present  = |(cell_bit & cfg.cells_present);
    assign is_open  = (item.mv <= cfg.open_low) || (item.mv > cfg.open_high);
    assign good     = present && !is_open;
    assign over     = item.mv > cfg.max_mv;
    assign cell_idx = IDX_W'(cnt_reg);

    always_comb
    begin
        // cycle start resets the trackers (low to open_high); index trackers hold
        cyc_next.sum      = start ? '0 : sum_reg;
        cyc_next.high_mv  = start ? '0 : high_reg;
        cyc_next.high_idx = hidx_reg;
        cyc_next.low_mv   = start ? cfg.open_high : low_reg;
        cyc_next.low_idx  = lidx_reg;
        cyc_next.over     = start ? '0 : over_reg;
        cyc_next.below    = start ? '0 : below_reg;
        cyc_next.vlow     = start ? '0 : vlow_reg;
        cyc_next.bal      = start ? '0 : bal_reg;
        cyc_next.status   = start ? '0 : status_reg;
        cyc_next.trip_set = '0;
        cyc_next.hyst_set = '0;

        if (present && is_open)
        begin
            cyc_next.status[ST_OPEN_BIT] = 1'b1;
        end

        if (good)
        begin
            if (item.mv > cyc_next.high_mv)
            begin
                cyc_next.high_mv  = item.mv;
                cyc_next.high_idx = cell_idx;
            end
            if (item.mv < cyc_next.low_mv)
            begin
                cyc_next.low_mv  = item.mv;
                cyc_next.low_idx = cell_idx;
            end
            if (over)
            begin
                cyc_next.over              = cyc_next.over | cell_bit;
                cyc_next.bal               = cyc_next.bal | cell_bit;
                cyc_next.trip_set          = cell_bit;
                cyc_next.status[ST_HIGH_BIT] = 1'b1;
            end
            // already tripped cells keep balancing above target in charge mode
            if ((item.mv > cfg.target_delta) && (|(trip_mask & cell_bit)) && !relax)
            begin
                cyc_next.bal = cyc_next.bal | cell_bit;
            end
            if (item.mv < cfg.hyst_low)
            begin
                cyc_next.hyst_set = cell_bit;
            end
            if (item.mv < cfg.min_mv)
            begin
                cyc_next.below              = cyc_next.below | cell_bit;
                cyc_next.status[ST_LOW_BIT] = 1'b1;
            end
            if (item.mv < cfg.very_low)
            begin
                cyc_next.vlow                = cyc_next.vlow | cell_bit;
                cyc_next.status[ST_VLOW_BIT] = 1'b1;
            end
            cyc_next.sum = cyc_next.sum + SUM_W'(item.mv);
        end
    end

    always_comb
    begin
        if (item.last)
        begin
            cnt_next = '0;
        end
        else if (cnt_reg < CNT_W'(NUM_CELLS))
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            sum_reg    <= '0;
            high_reg   <= '0;
            hidx_reg   <= '0;
            low_reg    <= RST_OPEN_HIGH;
            lidx_reg   <= '0;
            over_reg   <= '0;
            below_reg  <= '0;
            vlow_reg   <= '0;
            bal_reg    <= '0;
            status_reg <= '0;
        end
        else if (go)
        begin
            cnt_reg    <= cnt_next;
            sum_reg    <= cyc_next.sum;
            high_reg   <= cyc_next.high_mv;
            hidx_reg   <= cyc_next.high_idx;
            low_reg    <= cyc_next.low_mv;
            lidx_reg   <= cyc_next.low_idx;
            over_reg   <= cyc_next.over;
            below_reg  <= cyc_next.below;
            vlow_reg   <= cyc_next.vlow;
            bal_reg    <= cyc_next.bal;
            status_reg <= cyc_next.status;
        end
    end

    assign cyc = cyc_next;

endmodule

>>> hw/rtl/cbp_policy.sv
// End-of-cycle decision: FET policy, trip/relaxation mode and result register.
module cbp_policy (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        go,
    input  cbp_pkg::item_t              item,
    input  cbp_pkg::cfg_t               cfg,
    input  cbp_pkg::cyc_t               cyc,
    input  logic                        out_stall,
    output logic [cbp_pkg::MASK_W-1:0]  trip_mask,
    output logic                        relax,
    output logic                        out_valid,
    output logic [cbp_pkg::MASK_W-1:0]  balance_mask,
    output logic [cbp_pkg::FET_W-1:0]   fet_bits,
    output logic [cbp_pkg::STAT_W-1:0]  pack_status,
    output logic [cbp_pkg::MODE_W-1:0]  mode_bits,
    output logic [cbp_pkg::SUM_W-1:0]   total_mv,
    output logic [cbp_pkg::MV_W-1:0]    high_mv,
    output logic [cbp_pkg::IDX_W-1:0]   high_index,
    output logic [cbp_pkg::MV_W-1:0]    low_mv,
    output logic [cbp_pkg::IDX_W-1:0]   low_index,
    output logic [cbp_pkg::MASK_W-1:0]  over_max_mask,
    output logic [cbp_pkg::MASK_W-1:0]  below_min_mask,
    output logic [cbp_pkg::MASK_W-1:0]  very_low_mask
);
    import cbp_pkg::*;

    typedef enum logic [1:0] {
        TRIP_IDLE = 2'd0,
        TRIP_REQ  = 2'd1,
        TRIP_DONE = 2'd2
    } trip_t;

    logic [MASK_W-1:0] trip_mask_reg, trip_mask_next;
    logic [MASK_W-1:0] hyst_reg,      hyst_next;
    logic              relax_reg,     relax_next;
    trip_t             tc_reg,        tc_next;
    logic [FET_W-1:0]  fet_reg,       fet_next;
    logic              test_reg,      test_next;
    logic [MODE_W-1:0] mode_reg,      mode_next;
    logic              out_valid_reg, out_valid_next;
    logic [MASK_W-1:0] bal;
    logic              dump2_off_cmd;
    logic              high_over;
    logic              load;

    logic [MASK_W-1:0] bal_reg;
    logic [FET_W-1:0]  fet_out_reg;
    logic [STAT_W-1:0] status_reg;
    logic [MODE_W-1:0] mode_out_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [MV_W-1:0]   high_reg;
    logic [IDX_W-1:0]  hidx_reg;
    logic [MV_W-1:0]   low_reg;
    logic [IDX_W-1:0]  lidx_reg;
    logic [MASK_W-1:0] over_reg;
    logic [MASK_W-1:0] below_reg;
    logic [MASK_W-1:0] vlow_reg;

    assign load      = go && item.last;
    assign high_over = cyc.high_mv > cfg.max_mv;

    always_comb
    begin
        tc_next        = item.trip_req ? TRIP_REQ : tc_reg;
        test_next      = test_reg | item.test_req;
        trip_mask_next = trip_mask_reg | cyc.trip_set;
        hyst_next      = hyst_reg | cyc.hyst_set;
        relax_next     = relax_reg;
        fet_next       = fet_reg;
        mode_next      = mode_reg;
        bal            = cyc.bal;
        dump2_off_cmd  = item.cmd_active[FET_DUMP2_BIT] && !item.cmd_expired[FET_DUMP2_BIT]
                         && !item.cmd_on[FET_DUMP2_BIT];

        if (item.last)
        begin
            // command bits share positions with dump, dump2, heater FETs
            for (int i = 0; i < CMD_W; i++)
            begin
                if (item.cmd_expired[i])
                begin
                    fet_next[i] = 1'b0;
                end
                else if (item.cmd_active[i])
                begin
                    fet_next[i] = item.cmd_on[i];
                end
            end

            if (cyc.status[ST_OPEN_BIT])
            begin
                fet_next = '0;
                bal      = '0;
            end
            else
            begin
                if (cyc.below != '0)
                begin
                    fet_next[FET_DUMP_BIT]   = 1'b0;
                    fet_next[FET_HEATER_BIT] = 1'b0;
                    tc_next                  = TRIP_IDLE;
                    if (!high_over)
                    begin
                        bal = '0;
                    end
                end
                if (high_over)
                begin
                    fet_next[FET_CHGR_BIT]  = 1'b0;
                    fet_next[FET_DUMP2_BIT] = 1'b0;
                end
                else
                begin
                    fet_next[FET_CHGR_BIT] = 1'b1;
                end
                if (trip_mask_next == '0)
                begin
                    if (!dump2_off_cmd)
                    begin
                        fet_next[FET_DUMP2_BIT] = 1'b1;
                    end
                end
                else
                begin
                    fet_next[FET_DUMP2_BIT] = 1'b0;
                end

                if (!relax_reg)
                begin
                    if ((trip_mask_next == cfg.cells_present) || (tc_next == TRIP_REQ))
                    begin
                        hyst_next  = '0;
                        relax_next = 1'b1;
                        bal        = '0;
                        fet_next   = '0;
                        if (tc_next == TRIP_REQ)
                        begin
                            tc_next = TRIP_DONE;
                        end
                    end
                end
                else
                begin
                    if (cyc.over != '0)
                    begin
                        bal = cyc.over;
                    end
                    else
                    begin
                        bal = item.rb_active ? item.rb_mask : '0;
                    end
                    if (test_next)
                    begin
                        fet_next[FET_DUMP2_BIT] = 1'b0;
                        fet_next[FET_CHGR_BIT]  = 1'b0;
                        fet_next[FET_VLC_BIT]   = 1'b0;
                        fet_next[FET_DUMP_BIT]  = 1'b1;
                    end
                    else
                    begin
                        fet_next[FET_CHGR_BIT] = 1'b0;
                        fet_next[FET_VLC_BIT]  = 1'b0;
                    end
                    if ((hyst_next != '0) || (tc_next == TRIP_IDLE))
                    begin
                        tc_next        = TRIP_DONE;
                        relax_next     = 1'b0;
                        trip_mask_next = '0;
                        test_next      = 1'b0;
                    end
                end
                mode_next[MODE_RELAX_BIT] = relax_next;
                mode_next[MODE_TRIP_BIT]  = (trip_mask_next != '0);
            end
        end
    end

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trip_mask_reg <= '0;
            hyst_reg      <= '0;
            relax_reg     <= 1'b0;
            tc_reg        <= TRIP_IDLE;
            fet_reg       <= '0;
            test_reg      <= 1'b0;
            mode_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (go)
            begin
                trip_mask_reg <= trip_mask_next;
                hyst_reg      <= hyst_next;
                relax_reg     <= relax_next;
                tc_reg        <= tc_next;
                fet_reg       <= fet_next;
                test_reg      <= test_next;
                mode_reg      <= mode_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bal_reg      <= bal;
            fet_out_reg  <= fet_next;
            status_reg   <= cyc.status;
            mode_out_reg <= mode_next;
            sum_reg      <= cyc.sum;
            high_reg     <= cyc.high_mv;
            hidx_reg     <= cyc.high_idx;
            low_reg      <= cyc.low_mv;
            lidx_reg     <= cyc.low_idx;
            over_reg     <= cyc.over;
            below_reg    <= cyc.below;
            vlow_reg     <= cyc.vlow;
        end
    end

    assign trip_mask      = trip_mask_reg;
    assign relax          = relax_reg;
    assign out_valid      = out_valid_reg;
    assign balance_mask   = bal_reg;
    assign fet_bits       = fet_out_reg;
    assign pack_status    = status_reg;
    assign mode_bits      = mode_out_reg;
    assign total_mv       = sum_reg;
    assign high_mv        = high_reg;
    assign high_index     = hidx_reg;
    assign low_mv         = low_reg;
    assign low_index      = lidx_reg;
    assign over_max_mask  = over_reg;
    assign below_min_mask = below_reg;
    assign very_low_mask  = vlow_reg;

endmodule

>>> dv/tb_cell_balance_policy_top.sv
// Self-checking testbench for cell_balance_policy_top, with a cycle-level policy predictor.
module tb_cell_balance_policy_top;
    import cbp_pkg::*;

    localparam int CELLS          = 18;
    localparam int NUM_PHASES     = 10;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum logic [1:0] {TRIP_IDLE, TRIP_REQUESTED, TRIP_DONE} trip_code_e;

    typedef struct packed {
        logic [RAW_W-1:0]  reading;
        logic              last;
        logic [CMD_W-1:0]  cmd_active;
        logic [CMD_W-1:0]  cmd_on;
        logic [CMD_W-1:0]  cmd_expired;
        logic              rb_active;
        logic [MASK_W-1:0] rb_mask;
        logic              test_req;
        logic              trip_req;
    } cell_txn_t;

    typedef struct packed {
        logic [MASK_W-1:0] bal;
        logic [FET_W-1:0]  fet;
        logic [STAT_W-1:0] status;
        logic [MODE_W-1:0] mode;
        logic [SUM_W-1:0]  total;
        logic [MV_W-1:0]   high;
        logic [IDX_W-1:0]  high_idx;
        logic [MV_W-1:0]   low;
        logic [IDX_W-1:0]  low_idx;
        logic [MASK_W-1:0] over;
        logic [MASK_W-1:0] below;
        logic [MASK_W-1:0] vlow;
    } pack_report_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [RAW_W-1:0]      cell_reading;
    logic                  last_cell;
    logic [CMD_W-1:0]      cmd_active_mask;
    logic [CMD_W-1:0]      cmd_on_mask;
    logic [CMD_W-1:0]      cmd_expired_mask;
    logic                  remote_balance_active;
    logic [MASK_W-1:0]     remote_balance_mask;
    logic                  discharge_test_request;
    logic                  trip_request;
    logic                  out_valid;
    logic                  out_stall;
    logic [MASK_W-1:0]     balance_mask;
    logic [FET_W-1:0]      fet_bits;
    logic [STAT_W-1:0]     pack_status;
    logic [MODE_W-1:0]     mode_bits;
    logic [SUM_W-1:0]      total_mv;
    logic [MV_W-1:0]       high_mv;
    logic [IDX_W-1:0]      high_index;
    logic [MV_W-1:0]       low_mv;
    logic [IDX_W-1:0]      low_index;
    logic [MASK_W-1:0]     over_max_mask;
    logic [MASK_W-1:0]     below_min_mask;
    logic [MASK_W-1:0]     very_low_mask;

    cell_txn_t    in_txn;
    pack_report_t reports_due[$];
    int           mismatches;
    int           quiet_cycles;
    bit           gap_bursts;
    bit           stall_bursts;

    // predictor state
    cfg_t              shadow_cfg;
    logic [IDX_W-1:0]  cell_pos;
    logic [SUM_W-1:0]  run_sum;
    logic [MV_W-1:0]   run_high;
    logic [IDX_W-1:0]  run_high_idx;
    logic [MV_W-1:0]   run_low;
    logic [IDX_W-1:0]  run_low_idx;
    logic [MASK_W-1:0] over_acc;
    logic [MASK_W-1:0] below_acc;
    logic [MASK_W-1:0] vlow_acc;
    logic [MASK_W-1:0] bal_acc;
    logic [STAT_W-1:0] cyc_status;
    logic [MASK_W-1:0] tripped;
    logic [MASK_W-1:0] hyst_hits;
    logic              relaxing;
    trip_code_e        trip_state;
    logic [FET_W-1:0]  fet_hold;
    logic              test_latched;
    logic [MODE_W-1:0] mode_hold;

    assign cell_reading           = in_txn.reading;
    assign last_cell              = in_txn.last;
    assign cmd_active_mask        = in_txn.cmd_active;
    assign cmd_on_mask            = in_txn.cmd_on;
    assign cmd_expired_mask       = in_txn.cmd_expired;
    assign remote_balance_active  = in_txn.rb_active;
    assign remote_balance_mask    = in_txn.rb_mask;
    assign discharge_test_request = in_txn.test_req;
    assign trip_request           = in_txn.trip_req;

    cell_balance_policy_top #(
        .NUM_CELLS(CELLS)
    ) u_dut (
        .clk,
        .rst_n,
        .cfg_we,
        .cfg_index,
        .cfg_data,
        .in_valid,
        .in_stall,
        .cell_reading,
        .last_cell,
        .cmd_active_mask,
        .cmd_on_mask,
        .cmd_expired_mask,
        .remote_balance_active,
        .remote_balance_mask,
        .discharge_test_request,
        .trip_request,
        .out_valid,
        .out_stall,
        .balance_mask,
        .fet_bits,
        .pack_status,
        .mode_bits,
        .total_mv,
        .high_mv,
        .high_index,
        .low_mv,
        .low_index,
        .over_max_mask,
        .below_min_mask,
        .very_low_mask
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Folds one accepted reading into the running cycle trackers.
    function automatic void absorb_reading(cell_txn_t t);
        logic [MV_W-1:0]   mv;
        logic [MASK_W-1:0] cell_bit;
        mv = MV_W'(t.reading / 16'd10);
        if (t.trip_req)
            trip_state = TRIP_REQUESTED;
        if (t.test_req)
            test_latched = 1'b1;
        if (cell_pos == '0)
        begin
            run_sum    = '0;
            run_high   = '0;
            run_low    = shadow_cfg.open_high;
            over_acc   = '0;
            below_acc  = '0;
            vlow_acc   = '0;
            bal_acc    = '0;
            cyc_status = '0;
        end
        if (int'(cell_pos) < CELLS)
        begin
            cell_bit = MASK_W'(1) << cell_pos;
            if ((shadow_cfg.cells_present & cell_bit) != '0)
            begin
                if (mv <= shadow_cfg.open_low || mv > shadow_cfg.open_high)
                    cyc_status[ST_OPEN_BIT] = 1'b1;
                else
                begin
                    if (mv > run_high)
                    begin
                        run_high     = mv;
                        run_high_idx = cell_pos;
                    end
                    if (mv < run_low)
                    begin
                        run_low     = mv;
                        run_low_idx = cell_pos;
                    end
                    if (mv > shadow_cfg.max_mv)
                    begin
                        over_acc |= cell_bit;
                        bal_acc  |= cell_bit;
                        tripped  |= cell_bit;
                        cyc_status[ST_HIGH_BIT] = 1'b1;
                    end
                    // tripped cells keep bleeding down to the target in charge mode
                    if (mv > shadow_cfg.target_delta && (tripped & cell_bit) != '0 && !relaxing)
                        bal_acc |= cell_bit;
                    if (mv < shadow_cfg.hyst_low)
                        hyst_hits |= cell_bit;
                    if (mv < shadow_cfg.min_mv)
                    begin
                        below_acc |= cell_bit;
                        cyc_status[ST_LOW_BIT] = 1'b1;
                    end
                    if (mv < shadow_cfg.very_low)
                    begin
                        vlow_acc |= cell_bit;
                        cyc_status[ST_VLOW_BIT] = 1'b1;
                    end
                    run_sum = run_sum + SUM_W'(mv);
                end
            end
            cell_pos = cell_pos + IDX_W'(1);
        end
    endfunction

    // End-of-cycle decision: FET policy, mode switch and the report it produces.
    function automatic pack_report_t decide_policy(cell_txn_t t);
        pack_report_t      r;
        logic [FET_W-1:0]  fet;
        logic [MASK_W-1:0] bal;
        logic              dump2_off;
        fet = fet_hold;
        bal = bal_acc;
        // command bits line up with the low FET bits; expiry beats the command
        for (int i = 0; i < CMD_W; i++)
        begin
            if (t.cmd_expired[i])
                fet[i] = 1'b0;
            else if (t.cmd_active[i])
                fet[i] = t.cmd_on[i];
        end
        dump2_off = t.cmd_active[FET_DUMP2_BIT] && !t.cmd_expired[FET_DUMP2_BIT]
                    && !t.cmd_on[FET_DUMP2_BIT];

        if (cyc_status[ST_OPEN_BIT])
        begin
            fet_hold = '0;
            bal      = '0;
        end
        else
        begin
            if (below_acc != '0)
            begin
                fet[FET_DUMP_BIT]   = 1'b0;
                fet[FET_HEATER_BIT] = 1'b0;
                trip_state = TRIP_IDLE;
                if (run_high > shadow_cfg.max_mv)
                begin
                    fet[FET_CHGR_BIT]  = 1'b0;
                    fet[FET_DUMP2_BIT] = 1'b0;
                end
                else
                    bal = '0;
            end
            if (run_high > shadow_cfg.max_mv)
            begin
                fet[FET_CHGR_BIT]  = 1'b0;
                fet[FET_DUMP2_BIT] = 1'b0;
            end
            else
                fet[FET_CHGR_BIT] = 1'b1;
            if (tripped == '0)
            begin
                if (!dump2_off)
                    fet[FET_DUMP2_BIT] = 1'b1;
            end
            else
                fet[FET_DUMP2_BIT] = 1'b0;

            if (!relaxing)
            begin
                if (tripped == shadow_cfg.cells_present || trip_state == TRIP_REQUESTED)
                begin
                    hyst_hits = '0;
                    relaxing  = 1'b1;
                    bal       = '0;
                    fet       = '0;
                    if (trip_state == TRIP_REQUESTED)
                        trip_state = TRIP_DONE;
                end
            end
            else
            begin
                if (over_acc != '0)
                    bal = over_acc;
                else
                    bal = t.rb_active ? t.rb_mask : '0;
                if (test_latched)
                begin
                    fet[FET_DUMP2_BIT] = 1'b0;
                    fet[FET_CHGR_BIT]  = 1'b0;
                    fet[FET_VLC_BIT]   = 1'b0;
                    fet[FET_DUMP_BIT]  = 1'b1;
                end
                else
                begin
                    fet[FET_CHGR_BIT] = 1'b0;
                    fet[FET_VLC_BIT]  = 1'b0;
                end
                if (hyst_hits != '0 || trip_state == TRIP_IDLE)
                begin
                    trip_state   = TRIP_DONE;
                    relaxing     = 1'b0;
                    tripped      = '0;
                    test_latched = 1'b0;
                end
            end
            mode_hold[MODE_RELAX_BIT] = relaxing;
            mode_hold[MODE_TRIP_BIT]  = (tripped != '0);
            fet_hold = fet;
        end

        r.bal      = bal;
        r.fet      = fet_hold;
        r.status   = cyc_status;
        r.mode     = mode_hold;
        r.total    = run_sum;
        r.high     = run_high;
        r.high_idx = run_high_idx;
        r.low      = run_low;
        r.low_idx  = run_low_idx;
        r.over     = over_acc;
        r.below    = below_acc;
        r.vlow     = vlow_acc;
        cell_pos   = '0;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : scoreboard
        pack_report_t want;
        if (rst_n && in_valid && !in_stall)
        begin
            absorb_reading(in_txn);
            if (in_txn.last)
                reports_due.push_back(decide_policy(in_txn));
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (reports_due.size() == 0)
            begin
                $display("%0t: result with nothing expected, expected none actual %0h",
                         $time, balance_mask);
                mismatches++;
            end
            else
            begin
                want = reports_due.pop_front();
                check_field("balance_mask", 32'(want.bal), 32'(balance_mask));
                check_field("fet_bits", 32'(want.fet), 32'(fet_bits));
                check_field("pack_status", 32'(want.status), 32'(pack_status));
                check_field("mode_bits", 32'(want.mode), 32'(mode_bits));
                check_field("total_mv", 32'(want.total), 32'(total_mv));
                check_field("high_mv", 32'(want.high), 32'(high_mv));
                check_field("high_index", 32'(want.high_idx), 32'(high_index));
                check_field("low_mv", 32'(want.low), 32'(low_mv));
                check_field("low_index", 32'(want.low_idx), 32'(low_index));
                check_field("over_max_mask", 32'(want.over), 32'(over_max_mask));
                check_field("below_min_mask", 32'(want.below), 32'(below_min_mask));
                check_field("very_low_mask", 32'(want.vlow), 32'(very_low_mask));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    // receiver side back-pressure
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_bursts && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_cell(cell_txn_t t);
        if (gap_bursts && $urandom_range(0, 7) == 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 13)) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_txn   <= t;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Only between cycles: drain outstanding reports, let the pipe empty, then write.
    task automatic program_config(cfg_t c);
        @(negedge clk);
        in_valid <= 1'b0;
        while (reports_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        write_reg(REG_CELLS_PRESENT, CFG_DATA_W'(c.cells_present));
        write_reg(REG_OPEN_LOW, CFG_DATA_W'(c.open_low));
        write_reg(REG_OPEN_HIGH, CFG_DATA_W'(c.open_high));
        write_reg(REG_MAX, CFG_DATA_W'(c.max_mv));
        write_reg(REG_MIN, CFG_DATA_W'(c.min_mv));
        write_reg(REG_VERY_LOW, CFG_DATA_W'(c.very_low));
        write_reg(REG_TARGET_DELTA, CFG_DATA_W'(c.target_delta));
        write_reg(REG_HYST_LOW, CFG_DATA_W'(c.hyst_low));
        shadow_cfg = c;
    endtask

    function automatic cell_txn_t quiet_cell(logic [RAW_W-1:0] reading, logic last);
        cell_txn_t t;
        t         = '0;
        t.reading = reading;
        t.last    = last;
        return t;
    endfunction

    task automatic send_pair(logic [RAW_W-1:0] r0, logic [RAW_W-1:0] r1, logic test_req,
                             logic trip_req);
        cell_txn_t t;
        t = quiet_cell(r0, 1'b0);
        t.test_req = test_req;
        t.trip_req = trip_req;
        send_cell(t);
        t = quiet_cell(r1, 1'b1);
        t.rb_active = 1'b1;
        t.rb_mask   = MASK_W'($urandom);
        send_cell(t);
    endtask

    // Readings clustered around the active thresholds, with some wild ones mixed in.
    function automatic logic [RAW_W-1:0] pick_reading(int bias);
        int lo, hi, mv, raw, r;
        r = $urandom_range(0, 199);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r < 6)
            return RAW_W'($urandom);
        if (bias == 0)
        begin
            lo = int'(shadow_cfg.very_low) - 40;
            hi = int'(shadow_cfg.max_mv) + 40;
        end
        else if (bias == 1)
        begin
            lo = int'(shadow_cfg.target_delta) - 20;
            hi = int'(shadow_cfg.max_mv) + 60;
        end
        else
        begin
            lo = int'(shadow_cfg.very_low) - 30;
            hi = int'(shadow_cfg.hyst_low) + 30;
        end
        if (lo <= int'(shadow_cfg.open_low))
            lo = int'(shadow_cfg.open_low) + 1;
        if (hi > int'(shadow_cfg.open_high))
            hi = int'(shadow_cfg.open_high);
        if (lo > hi)
            return RAW_W'($urandom);
        mv  = lo + int'($urandom_range(0, hi - lo));
        raw = mv * 10 + int'($urandom_range(0, 9));
        if (raw > 65535)
            raw = 65535;
        return RAW_W'(raw);
    endfunction

    // Reset configuration: nothing installed, so every cycle flips the mode.
    task automatic test_no_cells();
        cell_txn_t t;
        t = quiet_cell('0, 1'b1);
        send_cell(t);
        t = quiet_cell('1, 1'b1);
        t.rb_active = 1'b1;
        t.rb_mask   = '1;
        send_cell(t);
    endtask

    task automatic test_open_wire();
        cfg_t      c;
        cell_txn_t t;
        c = shadow_cfg;
        c.cells_present = MASK_W'(3);
        c.open_low      = MV_W'(100);
        program_config(c);
        send_cell(quiet_cell(16'd1009, 1'b0));
        t = quiet_cell('1, 1'b1);
        t.cmd_active = '1;
        t.cmd_on     = '1;
        send_cell(t);
    endtask

    task automatic test_trip_and_relax();
        send_pair(16'd35010, 16'd34000, 1'b0, 1'b0);  // all present cells tripped
        send_pair(16'd34000, 16'd34000, 1'b1, 1'b0);  // relaxed with test switch, does not leave yet
        send_pair(16'd35010, 16'd35010, 1'b0, 1'b0);
        send_pair(16'd36000, 16'd34000, 1'b1, 1'b0);  // stays relaxed, over-max balancing
        send_pair(16'd32000, 16'd34000, 1'b0, 1'b0);  // hysteresis low ends it
        send_pair(16'd34000, 16'd34000, 1'b0, 1'b1);  // forced entry by request
    endtask

    task automatic test_commands_and_low();
        cfg_t      c;
        cell_txn_t t;
        c = shadow_cfg;
        c.cells_present = MASK_W'(1);
        program_config(c);
        t = quiet_cell(16'd30000, 1'b1);
        t.cmd_active = '1;
        t.cmd_on     = '1;
        send_cell(t);
        t.cmd_on = '0;
        send_cell(t);
        t.cmd_on      = '1;
        t.cmd_expired = '1;
        send_cell(t);
        t.cmd_active = '0;
        t.cmd_on     = '0;
        t.cmd_expired = '0;
        t.cmd_active[FET_DUMP2_BIT] = 1'b1;
        send_cell(t);
        t.cmd_active = '1;
        t.cmd_on     = '1;
        t.reading    = 16'd25990;
        send_cell(t);
        t.reading = 16'd25000;
        send_cell(t);
        t.reading = 16'd1000;
        send_cell(t);
    endtask

    task automatic test_random_phases();
        cfg_t      c;
        cell_txn_t t;
        int        phase_items, len, bias, quota, pick;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            pick = $urandom_range(0, 3);
            if (p == 0 || pick == 0)
                c.cells_present = '1;
            else if (pick == 1)
                c.cells_present = MASK_W'($urandom);
            else
                c.cells_present = MASK_W'($urandom & $urandom & $urandom);
            c.open_low     = MV_W'($urandom_range(0, 500));
            c.open_high    = MV_W'($urandom_range(5000, 6553));
            c.very_low     = MV_W'($urandom_range(2000, 3000));
            c.min_mv       = c.very_low + MV_W'($urandom_range(0, 200));
            c.hyst_low     = c.min_mv + MV_W'($urandom_range(0, 800));
            c.target_delta = c.hyst_low + MV_W'($urandom_range(0, 300));
            c.max_mv       = c.target_delta + MV_W'($urandom_range(0, 300));
            if (p == 1)
                c = '0;
            else if (p == 2)
            begin
                c.cells_present = '1;
                c.open_low      = MV_W'(6553);
                c.open_high     = MV_W'(6553);
                c.max_mv        = MV_W'(6553);
                c.min_mv        = MV_W'(6553);
                c.very_low      = MV_W'(6553);
                c.target_delta  = MV_W'(6553);
                c.hyst_low      = MV_W'(6553);
            end
            else if (p == 3)
            begin
                // every valid cell is over max, and every one below 6553 is also under min
                c.open_low     = '0;
                c.open_high    = MV_W'(6553);
                c.max_mv       = '0;
                c.min_mv       = MV_W'(6553);
                c.very_low     = MV_W'(6553);
                c.target_delta = '0;
                c.hyst_low     = MV_W'(6553);
            end
            program_config(c);
            gap_bursts   = (p != NUM_PHASES - 1) && (p % 3 != 1);
            stall_bursts = gap_bursts;
            quota = (p == 1 || p == 2) ? 60 : 200;
            phase_items = 0;
            while (phase_items < quota)
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    len = $urandom_range(1, 17);
                else if (pick == 1)
                    len = $urandom_range(19, 24);
                else
                    len = CELLS;
                bias = $urandom_range(0, 2);
                for (int i = 0; i < len; i++)
                begin
                    t.reading     = pick_reading(bias);
                    t.last        = (i == len - 1);
                    t.cmd_active  = CMD_W'($urandom);
                    t.cmd_on      = CMD_W'($urandom);
                    t.cmd_expired = CMD_W'($urandom);
                    t.rb_active   = 1'($urandom_range(0, 1));
                    t.rb_mask     = MASK_W'($urandom);
                    t.test_req    = ($urandom_range(0, 15) == 0);
                    t.trip_req    = ($urandom_range(0, 39) == 0);
                    send_cell(t);
                end
                phase_items += len;
            end
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        in_txn       = '0;
        mismatches   = 0;
        quiet_cycles = 0;
        gap_bursts   = 1'b0;
        stall_bursts = 1'b0;

        shadow_cfg.cells_present = '0;
        shadow_cfg.open_low      = '0;
        shadow_cfg.open_high     = RST_OPEN_HIGH;
        shadow_cfg.max_mv        = RST_MAX;
        shadow_cfg.min_mv        = RST_MIN;
        shadow_cfg.very_low      = RST_VERY_LOW;
        shadow_cfg.target_delta  = RST_TARGET_DELTA;
        shadow_cfg.hyst_low      = RST_HYST_LOW;
        cell_pos     = '0;
        run_sum      = '0;
        run_high     = '0;
        run_high_idx = '0;
        run_low      = RST_OPEN_HIGH;
        run_low_idx  = '0;
        over_acc     = '0;
        below_acc    = '0;
        vlow_acc     = '0;
        bal_acc      = '0;
        cyc_status   = '0;
        tripped      = '0;
        hyst_hits    = '0;
        relaxing     = 1'b0;
        trip_state   = TRIP_IDLE;
        fet_hold     = '0;
        test_latched = 1'b0;
        mode_hold    = '0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_no_cells();
        test_open_wire();
        test_trip_and_relax();
        test_commands_and_low();
        test_random_phases();

        @(negedge clk);
        in_valid <= 1'b0;
        while (reports_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
